// ===== rtl/srqa_pkg.sv =====
// shared types and codes for the ring queue addresser
package srqa_pkg;

  // field and register widths
  localparam int unsigned AddrW  = 24;
  localparam int unsigned CountW = 16;
  localparam int unsigned SlotW  = 13;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned ProdW  = SlotW + CountW;

  // request codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // error codes
  localparam logic [ErrW-1:0] ERR_NONE  = 3'd0;
  localparam logic [ErrW-1:0] ERR_BUSY  = 3'd1;
  localparam logic [ErrW-1:0] ERR_EMPTY = 3'd2;
  localparam logic [ErrW-1:0] ERR_SIZE  = 3'd3;
  localparam logic [ErrW-1:0] ERR_END   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_SLOT  = 2'd2;

  // reset values of the configuration registers
  localparam logic [AddrW-1:0]  BASE_RST  = 24'd0;
  localparam logic [CountW-1:0] COUNT_RST = 16'd16;
  localparam logic [SlotW-1:0]  SLOT_RST  = 13'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic multiply;  // register slot_bytes times index
    logic finish;    // check, update pointers, load the result
  } srqa_cmd_t;

endpackage

// ===== rtl/srqa_ctrl.sv =====
// controller state machine of the ring queue addresser
module srqa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srqa_pkg::srqa_cmd_t cmd_o
);
  import srqa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result register can take a new item
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.capture  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.multiply = (state_q == S_MUL);
  assign cmd_o.finish   = (state_q == S_FIN) && out_free;

  // next state and result valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // an accepted item always goes on to the multiply step
  a_capture_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_MUL))
    else $error("accepted item did not reach multiply step");

  // finishing an item presents a result next cycle
  a_finish_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished item produced no result");

  // a waiting result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before it was taken");

  // at most one datapath command at a time
  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.multiply, cmd_o.finish}))
    else $error("overlapping datapath commands");

endmodule

// ===== rtl/srqa_dp.sv =====
// datapath: configuration, pointers, address arithmetic and result register
module srqa_dp #(
  parameter int unsigned MEMORY_BYTES = 131072
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srqa_pkg::srqa_cmd_t           cmd_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [srqa_pkg::AddrW-1:0]    cfg_wdata_i,
  input  logic                          cmd_in_i,
  input  logic [srqa_pkg::CountW-1:0]   payload_bytes_i,
  input  logic [srqa_pkg::CountW-1:0]   dest_room_i,
  input  logic                          memory_busy_i,
  output logic                          accepted_o,
  output logic [srqa_pkg::ErrW-1:0]     error_code_o,
  output logic [srqa_pkg::AddrW-1:0]    slot_address_o,
  output logic [srqa_pkg::CountW-1:0]   fill_count_o,
  output logic                          overwrote_oldest_o
);
  import srqa_pkg::*;

  localparam int unsigned SumW = ProdW + 2;

  // configuration registers
  logic [AddrW-1:0]  base_q;
  logic [CountW-1:0] count_q;
  logic [SlotW-1:0]  slot_q;

  // queue state
  logic [CountW-1:0] wr_idx_q, wr_idx_d;
  logic [CountW-1:0] rd_idx_q, rd_idx_d;
  logic [CountW-1:0] occ_q, occ_d;

  // captured item and product
  logic              cmd_q;
  logic [CountW-1:0] payload_q;
  logic [CountW-1:0] room_q;
  logic              busy_q;
  logic [ProdW-1:0]  prod_q;

  // result register
  logic              acc_q, acc_d;
  logic [ErrW-1:0]   err_q, err_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic              over_q, over_d;

  logic [CountW-1:0] eff_count;
  logic [CountW-1:0] wr_next, rd_next;
  logic [SumW-1:0]   addr_full;
  logic [SumW-1:0]   end_full;
  logic [ErrW-1:0]   pre_err;
  logic              full;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      count_q <= COUNT_RST;
      slot_q  <= SLOT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE:  base_q  <= cfg_wdata_i;
        REG_COUNT: count_q <= cfg_wdata_i[CountW-1:0];
        REG_SLOT:  slot_q  <= cfg_wdata_i[SlotW-1:0];
        default: ;
      endcase
    end
  end

  // capture item, then form slot_bytes times index
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q     <= cmd_in_i;
      payload_q <= payload_bytes_i;
      room_q    <= dest_room_i;
      busy_q    <= memory_busy_i;
    end
    if (cmd_i.multiply) begin
      prod_q <= slot_q * ((cmd_q == CMD_ENQ) ? wr_idx_q : rd_idx_q);
    end
  end

  // wrap point and next indexes, zero count acts as one
  assign eff_count = (count_q == '0) ? CountW'(1) : count_q;
  assign wr_next   = ({1'b0, wr_idx_q} + 17'd1 >= {1'b0, eff_count}) ? '0
                   : wr_idx_q + CountW'(1);
  assign rd_next   = ({1'b0, rd_idx_q} + 17'd1 >= {1'b0, eff_count}) ? '0
                   : rd_idx_q + CountW'(1);
  assign full      = (occ_q >= eff_count);

  // full-width address and slot end
  assign addr_full = SumW'(base_q) + SumW'(prod_q);
  assign end_full  = addr_full + SumW'(slot_q);

  // request checks in priority order
  always_comb begin
    pre_err = ERR_NONE;
    priority if (busy_q) begin
      pre_err = ERR_BUSY;
    end else if (cmd_q == CMD_ENQ) begin
      if (payload_q > CountW'(slot_q)) pre_err = ERR_SIZE;
    end else if (occ_q == '0) begin
      pre_err = ERR_EMPTY;
    end else if (room_q < CountW'(slot_q)) begin
      pre_err = ERR_SIZE;
    end
  end

  // result and pointer update
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    occ_d    = occ_q;
    acc_d    = 1'b0;
    over_d   = 1'b0;
    addr_d   = '0;
    err_d    = pre_err;
    if (pre_err == ERR_NONE && {1'b0, end_full} > (SumW + 1)'(MEMORY_BYTES)) begin
      err_d = ERR_END;
    end
    if (err_d == ERR_NONE) begin
      acc_d  = 1'b1;
      addr_d = addr_full[AddrW-1:0];
      if (cmd_q == CMD_ENQ) begin
        wr_idx_d = wr_next;
        if (full) begin
          rd_idx_d = rd_next;
          occ_d    = eff_count;
          over_d   = 1'b1;
        end else begin
          occ_d = occ_q + CountW'(1);
        end
      end else begin
        rd_idx_d = rd_next;
        occ_d    = occ_q - CountW'(1);
      end
    end
  end

  // queue state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      occ_q    <= '0;
    end else if (cmd_i.finish) begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      occ_q    <= occ_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      acc_q  <= acc_d;
      err_q  <= err_d;
      addr_q <= addr_d;
      over_q <= over_d;
    end
  end

  assign accepted_o         = acc_q;
  assign error_code_o       = err_q;
  assign slot_address_o     = addr_q;
  assign fill_count_o       = occ_q;
  assign overwrote_oldest_o = over_q;

endmodule

// ===== rtl/sram_ring_queue_addresser.sv =====
// Ring queue addresser for slots held in an external byte-addressed memory.
// Each item is an enqueue or dequeue request; the result gives the slot's
// byte address (base_address + slot_bytes * index), an error code, the fill
// count after the request and whether an enqueue into a full queue dropped
// the oldest slot. Refused requests leave the pointers untouched. One item is
// worked on at a time in three steps: capture at acceptance, a registered
// 13 x 16 bit multiply of slot size by index, then the checks and pointer
// update that load the result register, after which the result is valid.
// A new item is accepted only once the previous one has loaded its result.
// A result not yet taken holds the following item in its last step; that item
// may be accepted meanwhile. Configuration writes take effect at once and do
// not reset the queue pointers.
module sram_ring_queue_addresser #(
  parameter int unsigned MEMORY_BYTES = 131072
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [srqa_pkg::AddrW-1:0]    cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [srqa_pkg::CountW-1:0]   payload_bytes_i,
  input  logic [srqa_pkg::CountW-1:0]   dest_room_i,
  input  logic                          memory_busy_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic [srqa_pkg::ErrW-1:0]     error_code_o,
  output logic [srqa_pkg::AddrW-1:0]    slot_address_o,
  output logic [srqa_pkg::CountW-1:0]   fill_count_o,
  output logic                          overwrote_oldest_o
);
  import srqa_pkg::*;

  srqa_cmd_t dp_cmd;

  // sequencing
  srqa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  // arithmetic and state
  srqa_dp #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_in_i           (cmd_i),
    .payload_bytes_i    (payload_bytes_i),
    .dest_room_i        (dest_room_i),
    .memory_busy_i      (memory_busy_i),
    .accepted_o         (accepted_o),
    .error_code_o       (error_code_o),
    .slot_address_o     (slot_address_o),
    .fill_count_o       (fill_count_o),
    .overwrote_oldest_o (overwrote_oldest_o)
  );

endmodule
